// ===== rtl/zsbf_pkg.sv =====
// Shared types and constants for the zlib stored-block framer.
// Holds the job descriptor passed from the front end to the back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package zsbf_pkg;

  // Input command codes.
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_DATA  = 1'b1
  } cmd_e;

  // Adler-32 modulus and the fixed zlib header bytes.
  localparam logic [16:0] ADLER_MOD = 17'd65521;
  localparam logic [7:0]  ZLIB_CMF  = 8'h78;
  localparam logic [7:0]  ZLIB_FLG  = 8'h01;

  // Output byte slots of one job, in emission order.
  localparam int unsigned NUM_SLOTS = 12;
  localparam logic [3:0] SLOT_CMF    = 4'd0;
  localparam logic [3:0] SLOT_FLG    = 4'd1;
  localparam logic [3:0] SLOT_BFINAL = 4'd2;
  localparam logic [3:0] SLOT_LEN_LO = 4'd3;
  localparam logic [3:0] SLOT_LEN_HI = 4'd4;
  localparam logic [3:0] SLOT_NLN_LO = 4'd5;
  localparam logic [3:0] SLOT_NLN_HI = 4'd6;
  localparam logic [3:0] SLOT_DATA   = 4'd7;
  localparam logic [3:0] SLOT_ADL_3  = 4'd8;
  localparam logic [3:0] SLOT_ADL_2  = 4'd9;
  localparam logic [3:0] SLOT_ADL_1  = 4'd10;
  localparam logic [3:0] SLOT_ADL_0  = 4'd11;

  // Depth of the job queue between front and back end.
  localparam int unsigned QUEUE_DEPTH = 4;

  // One classified input item: which byte groups to emit and their payload.
  typedef struct packed {
    logic        has_zhdr;
    logic        has_bhdr;
    logic        has_data;
    logic        has_trailer;
    logic        overrun;
    logic        bfinal;
    logic [15:0] blen;
    logic [7:0]  data;
    logic [31:0] adler;
  } job_t;

  // Slot enable mask of a job; bit i enables slot i.
  function automatic logic [NUM_SLOTS-1:0] job_mask(input job_t job);
    logic [NUM_SLOTS-1:0] mask;
    begin
      mask        = '0;
      mask[1:0]   = {2{job.has_zhdr}};
      mask[6:2]   = {5{job.has_bhdr}};
      mask[7]     = job.has_data;
      mask[11:8]  = {4{job.has_trailer}};
      return mask;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/zsbf_front.sv =====
// Front end of the zlib stored-block framer: accepts input items, keeps the
// stream state and Adler-32 sums, and turns each item into a job descriptor.
// Depends on zsbf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module zsbf_front #(
  parameter int unsigned MAX_BLOCK_BYTES = 65535
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // Configuration write channel
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [31:0]   cfg_data_i,
  // Input item
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          in_cmd_i,
  input  wire logic [7:0]    in_byte_i,
  // Job push into the queue
  output logic               job_valid_o,
  input  wire logic          job_ready_i,
  output zsbf_pkg::job_t     job_o
);
  import zsbf_pkg::*;

  localparam logic [31:0] MaxLen32 = 32'(MAX_BLOCK_BYTES);
  localparam logic [15:0] MaxLen16 = 16'(MAX_BLOCK_BYTES);

  logic [31:0] stream_len_q, stream_len_d;
  logic [15:0] low_q, low_d;
  logic [15:0] high_q, high_d;
  logic [31:0] taken_q, taken_d;
  logic [15:0] left_q, left_d;

  logic        accept;
  logic [31:0] remaining;
  logic        fits;
  logic [15:0] blen;
  logic [15:0] left_dec;
  logic [31:0] taken_inc;
  logic [16:0] sum_a;
  logic [16:0] sum_b;
  logic [15:0] low_new;
  logic [15:0] high_new;
  logic        at_end;
  logic        beyond;
  job_t        job;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = job_ready_i;
  assign job_valid_o = in_valid_i;
  assign job_o       = job;
  assign accept      = in_valid_i && job_ready_i;

  // Block length for a block opened now, and the byte counters.
  always_comb begin
    remaining = stream_len_q - taken_q;
    fits      = (remaining <= MaxLen32);
    blen      = fits ? remaining[15:0] : MaxLen16;
    left_dec  = ((left_q == 16'd0) ? blen : left_q) - 16'd1;
    taken_inc = taken_q + 32'd1;
    beyond    = (taken_q >= stream_len_q);
    at_end    = (taken_inc == stream_len_q);
  end

  // Adler-32 update with conditional subtraction of the modulus.
  always_comb begin
    sum_a    = {1'b0, low_q} + {9'd0, in_byte_i};
    low_new  = (sum_a >= ADLER_MOD) ? 16'(sum_a - ADLER_MOD) : sum_a[15:0];
    sum_b    = {1'b0, high_q} + {1'b0, low_new};
    high_new = (sum_b >= ADLER_MOD) ? 16'(sum_b - ADLER_MOD) : sum_b[15:0];
  end

  // Classification of the item into a job and the next stream state.
  always_comb begin
    job          = '0;
    stream_len_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : stream_len_q;
    low_d        = low_q;
    high_d       = high_q;
    taken_d      = taken_q;
    left_d       = left_q;
    if (in_cmd_i == CMD_START) begin
      job.has_zhdr = 1'b1;
      if (stream_len_q == 32'd0) begin
        job.has_bhdr    = 1'b1;
        job.bfinal      = 1'b1;
        job.has_trailer = 1'b1;
        job.adler       = 32'd1;
      end
      if (accept) begin
        low_d   = 16'd1;
        high_d  = 16'd0;
        taken_d = 32'd0;
        left_d  = 16'd0;
      end
    end else if (beyond) begin
      job.has_data = 1'b1;
      job.overrun  = 1'b1;
    end else begin
      job.has_bhdr    = (left_q == 16'd0);
      job.bfinal      = fits;
      job.blen        = blen;
      job.has_data    = 1'b1;
      job.data        = in_byte_i;
      job.has_trailer = at_end;
      job.adler       = {high_new, low_new};
      if (accept) begin
        low_d   = low_new;
        high_d  = high_new;
        taken_d = taken_inc;
        left_d  = at_end ? 16'd0 : left_dec;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_len_q <= 32'd0;
      low_q        <= 16'd1;
      high_q       <= 16'd0;
      taken_q      <= 32'd0;
      left_q       <= 16'd0;
    end else begin
      stream_len_q <= stream_len_d;
      low_q        <= low_d;
      high_q       <= high_d;
      taken_q      <= taken_d;
      left_q       <= left_d;
    end
  end

  // The running sums stay reduced below the modulus.
  a_low_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, low_q} < ADLER_MOD) && ({1'b0, high_q} < ADLER_MOD))
    else $error("Adler-32 sum not reduced");

  // A block never announces more bytes than the configured maximum.
  a_block_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && job.has_bhdr |-> job.blen <= MaxLen16)
    else $error("block length above maximum");

endmodule

`default_nettype wire

// ===== rtl/zsbf_queue.sv =====
// Short job queue between the front end and the back end of the framer.
// Register-based FIFO of job descriptors. Depends on zsbf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module zsbf_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  input  wire zsbf_pkg::job_t push_job_i,
  output logic               head_valid_o,
  output zsbf_pkg::job_t     head_job_o,
  input  wire logic          pop_i
);
  import zsbf_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  job_t                entries_q [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]       count_q, count_d;
  logic                push;
  logic                pop;

  assign push_ready_o = (count_q != (PtrW + 1)'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_job_o   = entries_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && head_valid_o;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage; payload only, no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_job_i;
    end
  end

  // Occupancy never exceeds the depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PtrW + 1)'(QUEUE_DEPTH))
    else $error("queue overfilled");

  // Pointers and occupancy stay consistent.
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) == count_q[PtrW-1:0])
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== rtl/zsbf_back.sv =====
// Back end, depends on zsbf_pkg: walks the head job's byte slots one per
// cycle unless the output stalls; drives the registered output stream.
`timescale 1ns / 1ps
`default_nettype none

module zsbf_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          head_valid_i,
  input  wire zsbf_pkg::job_t head_job_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               out_last_o,
  output logic               out_done_o,
  output logic               out_over_o
);
  import zsbf_pkg::*;

  logic [NUM_SLOTS-1:0] rem_q, rem_d;
  logic                 started_q, started_d;
  logic                 valid_q, valid_d;
  logic [7:0]           byte_q, byte_d;
  logic                 last_q, last_d;
  logic                 done_q, done_d;
  logic                 over_q, over_d;

  logic [NUM_SLOTS-1:0] cur_mask;
  logic [NUM_SLOTS-1:0] sel;
  logic [NUM_SLOTS-1:0] rem_next;
  logic [3:0]           slot;
  logic                 emit;
  logic                 is_last;
  logic [7:0]           slot_byte;

  // Pick the lowest slot still to be emitted for the head job.
  always_comb begin
    cur_mask = started_q ? rem_q : job_mask(head_job_i);
    sel      = cur_mask & (~cur_mask + 1'b1);
    rem_next = cur_mask & ~sel;
    is_last  = (rem_next == '0);
    slot     = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (sel[i]) begin
        slot = 4'(i);
      end
    end
  end

  // Byte of the selected slot.
  always_comb begin
    unique case (slot)
      SLOT_CMF:    slot_byte = ZLIB_CMF;
      SLOT_FLG:    slot_byte = ZLIB_FLG;
      SLOT_BFINAL: slot_byte = {7'd0, head_job_i.bfinal};
      SLOT_LEN_LO: slot_byte = head_job_i.blen[7:0];
      SLOT_LEN_HI: slot_byte = head_job_i.blen[15:8];
      SLOT_NLN_LO: slot_byte = ~head_job_i.blen[7:0];
      SLOT_NLN_HI: slot_byte = ~head_job_i.blen[15:8];
      SLOT_DATA:   slot_byte = head_job_i.data;
      SLOT_ADL_3:  slot_byte = head_job_i.adler[31:24];
      SLOT_ADL_2:  slot_byte = head_job_i.adler[23:16];
      SLOT_ADL_1:  slot_byte = head_job_i.adler[15:8];
      SLOT_ADL_0:  slot_byte = head_job_i.adler[7:0];
      default:     slot_byte = 8'h00;
    endcase
  end

  // Sequencing and the output register.
  always_comb begin
    emit      = head_valid_i && (!valid_q || out_ready_i);
    pop_o     = emit && is_last;
    rem_d     = rem_q;
    started_d = started_q;
    valid_d   = valid_q && !out_ready_i;
    byte_d    = byte_q;
    last_d    = last_q;
    done_d    = done_q;
    over_d    = over_q;
    if (emit) begin
      rem_d     = rem_next;
      started_d = !is_last;
      valid_d   = 1'b1;
      byte_d    = slot_byte;
      last_d    = is_last;
      done_d    = (slot == SLOT_ADL_0);
      over_d    = head_job_i.overrun && (slot == SLOT_DATA);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q     <= '0;
      started_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      rem_q     <= rem_d;
      started_q <= started_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    done_q <= done_d;
    over_q <= over_d;
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;
  assign out_done_o  = done_q;
  assign out_over_o  = over_q;

  // The final trailer byte and a dropped byte both end their item's run.
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && (done_q || over_q) |-> last_q)
    else $error("closing byte without last flag");

  // A job in progress always has slots left to emit.
  a_started_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |-> (rem_q != '0) && head_valid_i)
    else $error("job in progress without remaining slots");

endmodule

`default_nettype wire

// ===== rtl/zlib_stored_block_framer_unit.sv =====
// Top level of the zlib stored-block framer with Adler-32 trailer.
// Connects zsbf_front, zsbf_queue and zsbf_back; depends on zsbf_pkg.
//
//   Channel  Direction  Handshake               Payload
//   s_axis   in         s_axis_tvalid/tready    tdata data_byte, tuser command
//   m_axis   out        m_axis_tvalid/tready    tdata out_byte, tlast, tuser flags
//   cfg      in         cfg_valid_i/cfg_ready_o cfg_data_i = stream_length
//
// An item yields 1 result byte when it is a plain data byte, 6 when it opens a
// block, and up to 11 for a start on an empty stream. The back end's slot
// walker emits one byte per cycle while m_axis is not stalled. The first result
// of an item passes through the job queue and the back end's output register
// before it is valid on m_axis.
// Reset clears the stream state and stream_length; no clearing pass is needed.
// A four-entry job queue lets input and output stall independently.
`timescale 1ns / 1ps
`default_nettype none

module zlib_stored_block_framer_unit #(
  parameter int unsigned MAX_BLOCK_BYTES = 65535
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
  output logic             m_axis_tlast,   // last_of_run
  output logic [1:0]       m_axis_tuser    // [0] stream_done, [1] overrun
);
  import zsbf_pkg::*;

  logic job_valid;
  logic job_ready;
  job_t job;
  logic head_valid;
  job_t head_job;
  logic pop;
  logic out_done;
  logic out_over;

  zsbf_front #(
    .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (s_axis_tuser),
    .in_byte_i   (s_axis_tdata),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  zsbf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_valid),
    .push_ready_o (job_ready),
    .push_job_i   (job),
    .head_valid_o (head_valid),
    .head_job_o   (head_job),
    .pop_i        (pop)
  );

  zsbf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_job_i   (head_job),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast),
    .out_done_o   (out_done),
    .out_over_o   (out_over)
  );

  assign m_axis_tuser = {out_over, out_done};

endmodule

`default_nettype wire

// ===== sim/zlib_stored_block_framer_unit_tb.sv =====
// Self-checking testbench for the zlib stored-block framer with Adler-32 trailer.
// Predicts every output byte of zlib_stored_block_framer_unit in its own framing model;
// depends on zsbf_pkg for the command codes.
`timescale 1ns / 1ps

module zlib_stored_block_framer_unit_tb;
  import zsbf_pkg::cmd_e;
  import zsbf_pkg::CMD_START;
  import zsbf_pkg::CMD_DATA;

  // Framing constants, kept separate from the design's own copies.
  localparam int unsigned BLOCK_MAX       = 65535;
  localparam logic [16:0] ADLER_BASE      = 17'd65521;
  localparam logic [7:0]  ZHDR_CMF        = 8'h78;
  localparam logic [7:0]  ZHDR_FLG        = 8'h01;
  localparam int          RAND_ITEMS      = 340;
  localparam int          ADLER_RUN_LEN   = 270;
  localparam int          SETTLE_CYCLES   = 8;
  localparam int          WATCHDOG_CYCLES = 2000;

  typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_e;

  typedef struct {
    cmd_e       cmd;
    logic [7:0] data;
  } raw_item_t;

  typedef struct packed {
    logic [7:0] zbyte;
    logic       last;
    logic       done;
    logic       over;
  } zout_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic        s_axis_tuser;   // [0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [7:0] out_byte
  logic        m_axis_tlast;   // last_of_run
  logic [1:0]  m_axis_tuser;   // [0] stream_done, [1] overrun

  // Stimulus waiting to be sent and zlib bytes still owed by the block.
  raw_item_t   raw_pending[$];
  zout_t       zlib_bytes_due[$];
  zout_t       item_bytes[$];

  // Framing model state.
  logic [31:0] stream_len;
  logic [15:0] sum_lo;
  logic [15:0] sum_hi;
  logic [31:0] bytes_framed;
  logic [15:0] block_remaining;

  int          src_idle_pct;
  int          snk_stall_pct;
  bit          took_item;
  int          errors;
  int          items_in;
  int          bytes_checked;
  int          drops_seen;
  int          length_writes;
  int          quiet_cycles;

  zlib_stored_block_framer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= 10) begin
      $display("ERROR: %s", msg);
    end
  endfunction

  function automatic void add_byte(input logic [7:0] value, input logic done,
                                   input logic over);
    zout_t r;
    r.zbyte = value;
    r.last  = 1'b0;
    r.done  = done;
    r.over  = over;
    item_bytes = {item_bytes, r};
  endfunction

  // Stored block header: BFINAL, LEN little-endian, NLEN little-endian.
  function automatic void add_block_header(input logic is_final, input logic [15:0] blen);
    logic [15:0] nlen;
    nlen = ~blen;
    add_byte({7'd0, is_final}, 1'b0, 1'b0);
    add_byte(blen[7:0], 1'b0, 1'b0);
    add_byte(blen[15:8], 1'b0, 1'b0);
    add_byte(nlen[7:0], 1'b0, 1'b0);
    add_byte(nlen[15:8], 1'b0, 1'b0);
  endfunction

  // Adler-32 goes out big-endian; the final byte closes the stream.
  function automatic void add_adler_trailer();
    add_byte(sum_hi[15:8], 1'b0, 1'b0);
    add_byte(sum_hi[7:0], 1'b0, 1'b0);
    add_byte(sum_lo[15:8], 1'b0, 1'b0);
    add_byte(sum_lo[7:0], 1'b1, 1'b0);
  endfunction

  // Works out the zlib bytes that one accepted transaction produces.
  function automatic void frame_input(input cmd_e cmd, input logic [7:0] din);
    logic [31:0] remaining;
    logic        is_final;
    logic [15:0] blen;
    logic [16:0] a_next;
    logic [16:0] b_next;
    item_bytes.delete();
    if (cmd == CMD_START) begin
      sum_lo          = 16'd1;
      sum_hi          = 16'd0;
      bytes_framed    = 32'd0;
      block_remaining = 16'd0;
      add_byte(ZHDR_CMF, 1'b0, 1'b0);
      add_byte(ZHDR_FLG, 1'b0, 1'b0);
      if (stream_len == 32'd0) begin
        add_block_header(1'b1, 16'd0);
        add_adler_trailer();
      end
    end else if (bytes_framed >= stream_len) begin
      // Beyond the configured length: dropped and flagged, state kept.
      add_byte(8'h00, 1'b0, 1'b1);
    end else begin
      if (block_remaining == 16'd0) begin
        remaining = stream_len - bytes_framed;
        is_final  = (remaining <= BLOCK_MAX);
        blen      = is_final ? remaining[15:0] : BLOCK_MAX[15:0];
        add_block_header(is_final, blen);
        block_remaining = blen;
      end
      add_byte(din, 1'b0, 1'b0);
      block_remaining = block_remaining - 16'd1;
      bytes_framed    = bytes_framed + 32'd1;
      a_next = {1'b0, sum_lo} + {9'd0, din};
      if (a_next >= ADLER_BASE) begin
        a_next = a_next - ADLER_BASE;
      end
      b_next = {1'b0, sum_hi} + a_next;
      if (b_next >= ADLER_BASE) begin
        b_next = b_next - ADLER_BASE;
      end
      sum_lo = a_next[15:0];
      sum_hi = b_next[15:0];
      // The trailer follows the byte that reaches the length, even mid-block.
      if (bytes_framed == stream_len) begin
        add_adler_trailer();
        block_remaining = 16'd0;
      end
    end
    item_bytes[item_bytes.size() - 1].last = 1'b1;
    foreach (item_bytes[i]) begin
      zlib_bytes_due = {zlib_bytes_due, item_bytes[i]};
    end
  endfunction

  function automatic void check_output(input zout_t got);
    zout_t want;
    bytes_checked++;
    if (got.over) begin
      drops_seen++;
    end
    if (zlib_bytes_due.size() == 0) begin
      note_error($sformatf("unexpected output out=%02h last=%b done=%b over=%b",
                           got.zbyte, got.last, got.done, got.over));
      return;
    end
    want = zlib_bytes_due.pop_front();
    if (got.zbyte !== want.zbyte || got.last !== want.last ||
        got.done !== want.done || got.over !== want.over) begin
      note_error($sformatf({"output %0d: expected out=%02h last=%b done=%b over=%b, ",
                            "got out=%02h last=%b done=%b over=%b"}, bytes_checked,
                           want.zbyte, want.last, want.done, want.over,
                           got.zbyte, got.last, got.done, got.over));
    end
  endfunction

  function automatic void queue_item(input cmd_e cmd, input logic [7:0] data);
    raw_item_t it;
    it.cmd  = cmd;
    it.data = data;
    raw_pending = {raw_pending, it};
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void apply_idle(input idle_mode_e mode);
    case (mode)
      IDLE_SRC: begin
        src_idle_pct  = 47;
        snk_stall_pct = 0;
      end
      IDLE_SNK: begin
        src_idle_pct  = 0;
        snk_stall_pct = 47;
      end
      IDLE_BOTH: begin
        src_idle_pct  = 36;
        snk_stall_pct = 36;
      end
      default: begin
        src_idle_pct  = 0;
        snk_stall_pct = 0;
      end
    endcase
  endfunction

  // Waits until every queued transaction is taken and every byte has come out.
  task automatic drain_block();
    while (raw_pending.size() != 0 || s_axis_tvalid || zlib_bytes_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_length(input logic [31:0] value);
    @(negedge clk_i);
    cfg_data_i  = value;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Input driver: presents the oldest pending item, holding it until taken; also drives m_axis_tready.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
      if (s_axis_tvalid && !took_item) begin
        // Transaction still outstanding; keep it on the bus.
      end else if (raw_pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw_pending[0].data;
        s_axis_tuser  <= raw_pending[0].cmd;
      end else begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'($urandom);
        s_axis_tuser  <= 1'($urandom);
      end
      took_item = 1'b0;
    end
  end

  // Monitor: checks output transactions and feeds accepted inputs to the model.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_output({m_axis_tdata, m_axis_tlast, m_axis_tuser[0], m_axis_tuser[1]});
      end
      if (s_axis_tvalid && s_axis_tready) begin
        frame_input(cmd_e'(s_axis_tuser), s_axis_tdata);
        void'(raw_pending.pop_front());
        took_item = 1'b1;
        items_in++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        stream_len = cfg_data_i;
        length_writes++;
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("Timeout: no transaction for %0d cycles", WATCHDOG_CYCLES);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    int          phase;
    int          rand_items;
    int          body;
    int          r;
    logic [31:0] next_len;

    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = 32'd0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = 8'd0;
    s_axis_tuser    = 1'b0;
    m_axis_tready   = 1'b0;
    took_item       = 1'b0;
    stream_len      = 32'd0;
    sum_lo          = 16'd1;
    sum_hi          = 16'd0;
    bytes_framed    = 32'd0;
    block_remaining = 16'd0;
    errors          = 0;
    items_in        = 0;
    bytes_checked   = 0;
    drops_seen      = 0;
    length_writes   = 0;
    quiet_cycles    = 0;
    rand_items      = 0;
    apply_idle(IDLE_NONE);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Length zero out of reset: dropped data and the empty stream.
    queue_item(CMD_DATA, 8'h00);
    queue_item(CMD_START, 8'hFF);
    queue_item(CMD_DATA, 8'hFF);
    drain_block();

    // Data with no start frames from the reset state; then a full short stream.
    program_length(32'd2);
    queue_item(CMD_DATA, 8'h80);
    queue_item(CMD_DATA, 8'h01);
    queue_item(CMD_DATA, 8'h7E);
    queue_item(CMD_START, 8'h00);
    queue_item(CMD_DATA, 8'hFF);
    queue_item(CMD_DATA, 8'h00);
    drain_block();

    // Largest length: the first block is a full non-final one.
    apply_idle(IDLE_BOTH);
    program_length(32'hFFFF_FFFF);
    queue_item(CMD_START, 8'h55);
    queue_item(CMD_DATA, 8'hFF);
    queue_item(CMD_DATA, 8'h00);
    queue_item(CMD_DATA, 8'hA5);
    drain_block();

    // Length cut mid-block: the trailer comes inside the announced block.
    program_length(32'd4);
    queue_item(CMD_DATA, 8'h5C);
    queue_item(CMD_DATA, 8'h33);
    drain_block();

    // Length raised again: a fresh block opens from the remaining count.
    program_length(32'd65540);
    queue_item(CMD_DATA, 8'h11);
    queue_item(CMD_DATA, 8'h22);
    drain_block();
    program_length(32'd7);
    queue_item(CMD_DATA, 8'h44);
    drain_block();
    program_length(32'd9);
    queue_item(CMD_DATA, 8'h55);
    queue_item(CMD_DATA, 8'h66);
    drain_block();

    // One full block exactly, and one byte more than a block.
    program_length(32'd65535);
    queue_item(CMD_START, 8'h00);
    queue_item(CMD_DATA, 8'hC3);
    drain_block();
    program_length(32'd65536);
    queue_item(CMD_START, 8'h00);
    queue_item(CMD_DATA, 8'h3C);

    // Random phases: mostly complete streams, some truncated or overrun.
    phase = 0;
    while (rand_items < RAND_ITEMS) begin
      drain_block();
      apply_idle(idle_mode_e'(phase % 4));
      if (phase == 3) begin
        // Long run of high bytes so the low Adler sum wraps past the modulus.
        program_length(32'(ADLER_RUN_LEN));
        queue_item(CMD_START, 8'($urandom));
        repeat (ADLER_RUN_LEN) queue_item(CMD_DATA, 8'($urandom_range(240, 255)));
        rand_items += ADLER_RUN_LEN + 1;
      end else begin
        case ($urandom_range(9))
          0:       next_len = 32'd0;
          1:       next_len = 32'hFFFF_FFFF;
          2:       next_len = 32'd65535 + 32'($urandom_range(1));
          3:       next_len = 32'($urandom_range(25, 40));
          default: next_len = 32'($urandom_range(1, 12));
        endcase
        program_length(next_len);
        repeat ($urandom_range(1, 3)) begin
          // Leaving out the start continues the old stream under the new length.
          if ($urandom_range(99) < 85) begin
            queue_item(CMD_START, 8'($urandom));
            rand_items++;
          end
          body = (next_len <= 32'd40) ? int'(next_len) : $urandom_range(1, 16);
          r = $urandom_range(99);
          if (r < 10) begin
            body = $urandom_range(0, body);
          end else if (r < 20) begin
            body += $urandom_range(1, 3);
          end
          repeat (body) begin
            queue_item(CMD_DATA, pick_byte());
            rand_items++;
          end
        end
      end
      phase++;
    end
    drain_block();

    $display("Covered %0d input transactions over %0d length settings (%0d random phases).",
             items_in, length_writes, phase);
    $display("Checked %0d zlib output bytes, %0d of them dropped-byte flags; %0d mismatches.",
             bytes_checked, drops_seen, errors);
    if (errors == 0 && zlib_bytes_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
